FILE: src/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types, character codes and match tables for the request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

  localparam int MAX_LINE_DEF = 8192;
  localparam int TGT_W        = 13;
  localparam int QUEUE_DEPTH  = 2;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_PAD_W    = 3;
  localparam int OUT_TDATA_W  = 48;
  localparam int VOFF_W       = 4;

  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_SLASH    = 8'h2F;

  localparam logic [VOFF_W-1:0] VOFF_SAT    = 4'd9;
  localparam logic [VOFF_W-1:0] VER_LEN     = 4'd8;
  localparam logic [VOFF_W-1:0] VER_PFX_LEN = 4'd5;

  localparam int METH_NUM = 3;
  localparam int VER_NUM  = 2;

  localparam logic [7:0] METH_TXT [METH_NUM][8] = '{
    '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h00, 8'h00}
  };
  localparam logic [2:0] METH_LEN [METH_NUM] = '{3'd3, 3'd4, 3'd6};

  localparam logic [7:0] VER_TXT [VER_NUM][8] = '{
    '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h30},
    '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h31}
  };

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_VERSION = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    M_GET     = 2'd0,
    M_POST    = 2'd1,
    M_DELETE  = 2'd2,
    M_UNKNOWN = 2'd3
  } method_t;

  typedef enum logic {
    V_10 = 1'b0,
    V_11 = 1'b1
  } version_t;

  typedef enum logic [1:0] {
    SC_NONE  = 2'd0,
    SC_ONE   = 2'd1,
    SC_TWO   = 2'd2,
    SC_THREE = 2'd3
  } space_cnt_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_space;
    logic       is_question;
    logic       is_slash;
  } byte_item_t;

endpackage

FILE: src/hrlp_front.sv
// ----------------------------------------------------------------------------
// hrlp_front
// Input side: takes line bytes and tags each with its character class.
// ----------------------------------------------------------------------------
module hrlp_front import hrlp_pkg::*; (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // [7:0] line_byte
  input  logic                  in_tlast,
  output logic                  push_valid,
  input  logic                  push_ready,
  output byte_item_t            push_item
);

  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;

  always_comb begin
    push_item.data        = in_tdata[7:0];
    push_item.last        = in_tlast;
    push_item.is_space    = (in_tdata[7:0] == CH_SPACE);
    push_item.is_question = (in_tdata[7:0] == CH_QUESTION);
    push_item.is_slash    = (in_tdata[7:0] == CH_SLASH);
  end

endmodule

FILE: src/hrlp_queue.sv
// ----------------------------------------------------------------------------
// hrlp_queue
// Short queue of classified bytes between the input side and the parser core.
// ----------------------------------------------------------------------------
module hrlp_queue import hrlp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  byte_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output byte_item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  byte_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: src/hrlp_core.sv
// ----------------------------------------------------------------------------
// hrlp_core
// Parser core: tracks spaces, method and version matches and target layout,
// and registers one verdict per line on the final byte.
// ----------------------------------------------------------------------------
module hrlp_core import hrlp_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  byte_item_t             item,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int CNT_W = $clog2(MAX_LINE + 1);
  localparam int POS_W = $clog2(MAX_LINE);
  localparam int XW    = (POS_W > TGT_W) ? POS_W : TGT_W;

  logic [CNT_W-1:0]  pos_r, pos_nxt;
  space_cnt_t        sc_r, sc_nxt;
  logic [POS_W-1:0]  first_r, first_nxt;
  logic [POS_W-1:0]  second_r, second_nxt;
  logic [POS_W-1:0]  q_r, q_nxt;
  logic [2:0]        mc_r, mc_nxt;
  logic [2:0]        vc_r, vc_nxt;
  logic              slash_ok_r, slash_ok_nxt;
  logic              slash_pend_r, slash_pend_nxt;
  logic              qseen_r, qseen_nxt;
  logic              too_long_r, too_long_nxt;
  logic [VOFF_W-1:0] vo_r, vo_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, res_status;
  method_t           meth_r, res_meth;
  version_t          ver_r, res_ver;
  logic [TGT_W-1:0]  toff_r, res_toff;
  logic [TGT_W-1:0]  tlen_r, res_tlen;
  logic [TGT_W-1:0]  plen_r, res_plen;
  logic              qp_r, res_qp;

  logic              pop, end_line;
  logic [POS_W-1:0]  pos_p;
  logic [POS_W-1:0]  tlen_full, plen_full;
  logic [XW-1:0]     toff_x, tlen_x, plen_x;

  assign item_ready = !item.last || !out_valid_r || out_tready;
  assign pop        = item_valid && item_ready;
  assign end_line   = pop && item.last;
  assign pos_p      = pos_r[POS_W-1:0];

  always_comb begin
    logic keep;
    keep           = 1'b0;
    pos_nxt        = pos_r;
    sc_nxt         = sc_r;
    first_nxt      = first_r;
    second_nxt     = second_r;
    q_nxt          = q_r;
    mc_nxt         = mc_r;
    vc_nxt         = vc_r;
    slash_ok_nxt   = slash_ok_r;
    slash_pend_nxt = slash_pend_r;
    qseen_nxt      = qseen_r;
    too_long_nxt   = too_long_r;
    vo_nxt         = vo_r;
    if (pop) begin
      if (pos_r >= CNT_W'(MAX_LINE)) begin
        too_long_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + 1'b1;
        case (sc_r)
          SC_NONE: begin
            for (int k = 0; k < METH_NUM; k++) begin
              if (item.is_space) begin
                keep = (pos_r == CNT_W'(METH_LEN[k]));
              end else begin
                keep = (pos_r < CNT_W'(METH_LEN[k])) &&
                       (METH_TXT[k][pos_r[2:0]] == item.data);
              end
              if (!keep) begin
                mc_nxt[k] = 1'b0;
              end
            end
          end
          SC_ONE: begin
            if (!item.is_space) begin
              if (slash_pend_r) begin
                slash_ok_nxt = item.is_slash;
              end
              if (item.is_question && !qseen_r) begin
                q_nxt     = pos_p;
                qseen_nxt = 1'b1;
              end
            end
          end
          SC_TWO: begin
            if (!item.is_space) begin
              for (int k = 0; k < VER_NUM; k++) begin
                if (!((vo_r < VER_LEN) && (VER_TXT[k][vo_r[2:0]] == item.data))) begin
                  vc_nxt[k] = 1'b0;
                end
              end
              if ((vo_r < VER_PFX_LEN) && (VER_TXT[0][vo_r[2:0]] != item.data)) begin
                vc_nxt[2] = 1'b0;
              end
              if (vo_r < VOFF_SAT) begin
                vo_nxt = vo_r + 1'b1;
              end
            end
          end
          default: ;
        endcase
        slash_pend_nxt = 1'b0;
        if (item.is_space) begin
          if (sc_r == SC_NONE) begin
            first_nxt      = pos_p;
            slash_pend_nxt = 1'b1;
          end else if (sc_r == SC_ONE) begin
            second_nxt = pos_p;
          end
          if (sc_r != SC_THREE) begin
            sc_nxt = space_cnt_t'(sc_r + 2'd1);
          end
        end
      end
    end
  end

  assign tlen_full = second_nxt - first_nxt - 1'b1;
  assign plen_full = q_nxt - first_nxt - 1'b1;
  assign toff_x    = XW'(first_nxt) + 1'b1;
  assign tlen_x    = XW'(tlen_full);
  assign plen_x    = XW'(plen_full);

  always_comb begin
    res_status = ST_BAD;
    res_meth   = M_UNKNOWN;
    res_ver    = V_10;
    res_toff   = '0;
    res_tlen   = '0;
    res_plen   = '0;
    res_qp     = 1'b0;
    if (!too_long_nxt && (sc_nxt == SC_TWO)) begin
      if (mc_nxt[0]) begin
        res_meth = M_GET;
      end else if (mc_nxt[1]) begin
        res_meth = M_POST;
      end else if (mc_nxt[2]) begin
        res_meth = M_DELETE;
      end else begin
        res_meth = M_UNKNOWN;
      end
      res_toff = toff_x[TGT_W-1:0];
      res_tlen = tlen_x[TGT_W-1:0];
      res_plen = qseen_nxt ? plen_x[TGT_W-1:0] : tlen_x[TGT_W-1:0];
      res_qp   = qseen_nxt;
      if ((first_nxt == '0) || (tlen_full == '0) || (vo_nxt == '0)) begin
        res_status = ST_BAD;
      end else if ((vo_nxt == VER_LEN) && (vc_nxt[1:0] != 2'b00)) begin
        res_ver    = vc_nxt[0] ? V_10 : V_11;
        res_status = slash_ok_nxt ? ST_OK : ST_BAD;
      end else if ((vo_nxt >= VER_PFX_LEN) && vc_nxt[2]) begin
        res_status = ST_VERSION;
      end else begin
        res_status = ST_BAD;
      end
      if (res_status != ST_OK) begin
        res_ver = V_10;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || end_line) begin
      pos_r        <= '0;
      sc_r         <= SC_NONE;
      first_r      <= '0;
      second_r     <= '0;
      q_r          <= '0;
      mc_r         <= 3'b111;
      vc_r         <= 3'b111;
      slash_ok_r   <= 1'b0;
      slash_pend_r <= 1'b0;
      qseen_r      <= 1'b0;
      too_long_r   <= 1'b0;
      vo_r         <= '0;
    end else begin
      pos_r        <= pos_nxt;
      sc_r         <= sc_nxt;
      first_r      <= first_nxt;
      second_r     <= second_nxt;
      q_r          <= q_nxt;
      mc_r         <= mc_nxt;
      vc_r         <= vc_nxt;
      slash_ok_r   <= slash_ok_nxt;
      slash_pend_r <= slash_pend_nxt;
      qseen_r      <= qseen_nxt;
      too_long_r   <= too_long_nxt;
      vo_r         <= vo_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (end_line) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (end_line) begin
      status_r <= res_status;
      meth_r   <= res_meth;
      ver_r    <= res_ver;
      toff_r   <= res_toff;
      tlen_r   <= res_tlen;
      plen_r   <= res_plen;
      qp_r     <= res_qp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, qp_r, plen_r, tlen_r, toff_r, ver_r, meth_r, status_r};

endmodule

FILE: src/http_request_line_parser.sv
// ----------------------------------------------------------------------------
// http_request_line_parser
// Streaming checker for one request line: method, target layout and version.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                               | tlast
//  in_     | in  | [7:0] line_byte                     | end_of_line
//  out_    | out | status, method, version, target,... | -
//
//  One byte per cycle unless a held result stalls a final byte; the result is
//  registered in the cycle after the queue hands the final byte to the core.
//  Bytes pass through the two-entry queue, which registers each one.
//  Reset is synchronous and clears the queue and the line state.
//  A held result stalls only the final byte of the next line; other bytes
//  keep flowing into the core.
// ----------------------------------------------------------------------------
module http_request_line_parser import hrlp_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] line_byte
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [1:0] status, [3:2] method_code, [4] version_code, [17:5] target_offset,
  // [30:18] target_length, [43:31] path_length, [44] query_present, [47:45] 0
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic       push_valid, push_ready;
  byte_item_t push_item;
  logic       pop_valid, pop_ready;
  byte_item_t pop_item;

  hrlp_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  hrlp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  hrlp_core #(
    .MAX_LINE (MAX_LINE)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (pop_valid),
    .item_ready (pop_ready),
    .item       (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: src/hrlp_chk.sv
// ----------------------------------------------------------------------------
// hrlp_chk
// Port-level checks on the request line parser's result channel.
// ----------------------------------------------------------------------------
module hrlp_chk import hrlp_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("undefined status code");

  a_version_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != ST_OK) |-> !out_tdata[4])
    else $error("version code set on failed line");

  a_path_no_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[44] |-> out_tdata[43:31] == out_tdata[30:18])
    else $error("path length differs from target length without query");

endmodule

bind http_request_line_parser hrlp_chk u_chk (.*);
